// ----- rtl/ntsp_pkg.sv -----
package ntsp_pkg;

   localparam int STACK_DEPTH = 64;
   localparam int STACK_AW    = $clog2(STACK_DEPTH);
   localparam int NODE_BITS   = 16;
   localparam logic [15:0] NODE_MASK =
      (NODE_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << NODE_BITS) - 32'd1);

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   localparam logic [2:0] KIND_RECORD = 3'd1;
   localparam logic [2:0] KIND_LABEL  = 3'd2;
   localparam logic [2:0] KIND_BRANCH = 3'd3;
   localparam logic [2:0] KIND_STOP   = 3'd4;

   localparam logic [3:0] ERR_NONE       = 4'd0;
   localparam logic [3:0] ERR_OPEN       = 4'd1;
   localparam logic [3:0] ERR_LABEL      = 4'd2;
   localparam logic [3:0] ERR_COMMA      = 4'd3;
   localparam logic [3:0] ERR_COLON      = 4'd4;
   localparam logic [3:0] ERR_CLOSE      = 4'd5;
   localparam logic [3:0] ERR_UNBALANCED = 4'd6;
   localparam logic [3:0] ERR_SEMI       = 4'd7;
   localparam logic [3:0] ERR_LENGTH     = 4'd8;
   localparam logic [3:0] ERR_EXPONENT   = 4'd9;
   localparam logic [3:0] ERR_COMMENT    = 4'd10;
   localparam logic [3:0] ERR_BYTE       = 4'd11;
   localparam logic [3:0] ERR_OVERFLOW   = 4'd12;

   // everything one byte causes, in output order: record, passed byte, stop
   typedef struct packed {
      logic        rec_v;
      logic [15:0] rec_edge;
      logic [15:0] rec_parent;
      logic [15:0] rec_child;
      logic        pass_v;
      logic        pass_branch;
      logic [7:0]  pass_char;
      logic [15:0] pass_edge;
      logic        stop_v;
      logic [3:0]  stop_err;
   } action_type;

   typedef struct packed {
      logic push;
      logic pop;
   } stack_op_type;

endpackage

// ----- rtl/ntsp_ram.sv -----
module ntsp_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/ntsp_stack.sv -----
module ntsp_stack (
   input  logic                       clock,
   input  logic                       reset,
   input  ntsp_pkg::stack_op_type     op,
   input  logic [15:0]                push_data,
   output logic [15:0]                top,
   output logic [ntsp_pkg::STACK_AW:0] count
);

   localparam int AW = ntsp_pkg::STACK_AW;

   logic [15:0] top_ff, top_in;
   logic [AW:0] cnt_ff, cnt_in;
   logic        byp_ff, byp_in;
   logic [15:0] byp_val_ff;
   logic [15:0] below;
   logic [15:0] ram_q;
   logic [AW:0] rd_full;
   logic [AW:0] wr_full;

   // entry under the top: fresh from the RAM, or the old top right after a push
   assign below = byp_ff ? byp_val_ff : ram_q;

   always_comb begin
      top_in = top_ff;
      cnt_in = cnt_ff;
      byp_in = 1'b0;
      if (op.push) begin
         top_in = push_data;
         cnt_in = cnt_ff + 1'b1;
         byp_in = 1'b1;
      end else if (op.pop) begin
         top_in = below;
         cnt_in = cnt_ff - 1'b1;
      end
   end

   assign rd_full = cnt_in - (AW+1)'(2);
   assign wr_full = cnt_ff - (AW+1)'(1);

   ntsp_ram #(.WIDTH(16), .DEPTH(ntsp_pkg::STACK_DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (op.push && (cnt_ff != '0)),
      .wr_addr (wr_full[AW-1:0]),
      .wr_data (top_ff),
      .rd_addr (rd_full[AW-1:0]),
      .rd_data (ram_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         byp_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         byp_ff <= byp_in;
      end
      top_ff     <= top_in;
      byp_val_ff <= top_ff;
   end

   assign top   = top_ff;
   assign count = cnt_ff;

endmodule

// ----- rtl/ntsp_front.sv -----
module ntsp_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  logic [7:0]                  text_byte,
   input  logic                        end_of_text,
   input  logic                        csr_wr_en,
   input  logic [15:0]                 csr_wr_data,
   input  logic [15:0]                 open_top,
   input  logic [ntsp_pkg::STACK_AW:0] open_cnt,
   input  logic [15:0]                 pend_top,
   input  logic [ntsp_pkg::STACK_AW:0] pend_cnt,
   output ntsp_pkg::stack_op_type      open_op,
   output ntsp_pkg::stack_op_type      pend_op,
   output logic [15:0]                 push_id,
   output logic                        act_push,
   output ntsp_pkg::action_type        act
);

   typedef enum logic [2:0] {
      T_FIRST, T_OPEN, T_CLOSE, T_COMMA, T_COLON, T_SEMI, T_LABEL, T_BRANCH
   } token_type;

   typedef enum logic [2:0] {
      P_BETWEEN, P_COMMENT, P_LABEL, P_INT, P_FRAC, P_EXP0, P_EXPD
   } phase_type;

   typedef enum logic [3:0] {
      C_IGN, C_WS, C_LABEL, C_OPEN, C_CLOSE, C_PLUS, C_COMMA, C_DASH, C_DOT,
      C_DIGIT, C_COLON, C_SEMI, C_LSQ, C_RSQ, C_BAD
   } class_type;

   function automatic class_type class_of(input logic [7:0] b);
      class_type r;
      if (b[7]) begin
         r = C_BAD;
      end else if (b == 8'd9 || b == 8'd10 || b == 8'd13 || b == 8'd32) begin
         r = C_WS;
      end else if (b < 8'd32 || b == 8'd127) begin
         r = C_IGN;
      end else if (b >= "0" && b <= "9") begin
         r = C_DIGIT;
      end else begin
         case (b)
            "(":     r = C_OPEN;
            ")":     r = C_CLOSE;
            "+":     r = C_PLUS;
            ",":     r = C_COMMA;
            "-":     r = C_DASH;
            ".":     r = C_DOT;
            ":":     r = C_COLON;
            ";":     r = C_SEMI;
            "[":     r = C_LSQ;
            "]":     r = C_RSQ;
            default: r = C_LABEL;
         endcase
      end
      return r;
   endfunction

   localparam logic [ntsp_pkg::STACK_AW:0] DEPTH_FULL =
      (ntsp_pkg::STACK_AW+1)'(ntsp_pkg::STACK_DEPTH);

   phase_type   phase_ff, phase_in;
   token_type   prev_ff, prev_in;
   logic [15:0] tipc_ff, tipc_in;
   logic [15:0] intc_ff, intc_in;
   logic [15:0] edge_ff, edge_in;
   logic        halt_ff, halt_in;

   always_comb begin
      class_type   c;
      logic        consumed;
      logic        expm;
      logic        namech;
      logic [15:0] otop;
      logic        rec_pend;
      logic        rec_tip;

      c        = class_of(text_byte);
      expm     = (text_byte == "E") || (text_byte == "e");
      namech   = (c == C_LABEL) || (c == C_DIGIT) || (c == C_DOT) ||
                 (c == C_PLUS) || (c == C_DASH);
      otop     = (open_cnt != '0) ? open_top : 16'd0;
      consumed = 1'b0;
      rec_pend = 1'b0;
      rec_tip  = 1'b0;
      phase_in = phase_ff;
      prev_in  = prev_ff;
      tipc_in  = tipc_ff;
      intc_in  = intc_ff;
      edge_in  = edge_ff;
      halt_in  = halt_ff;
      open_op  = '0;
      pend_op  = '0;
      act      = '0;

      if (!halt_ff) begin
         // continue a token in progress
         case (phase_ff)
            P_COMMENT: begin
               if (c == C_RSQ) phase_in = P_BETWEEN;
               consumed = 1'b1;
            end
            P_LABEL: begin
               if (namech) begin
                  act.pass_v = 1'b1;
                  consumed   = 1'b1;
               end
            end
            P_INT, P_FRAC: begin
               if (c == C_DIGIT) begin
                  act.pass_v = 1'b1;
                  consumed   = 1'b1;
               end else if (c == C_DOT && phase_ff == P_INT) begin
                  act.pass_v = 1'b1;
                  phase_in   = P_FRAC;
                  consumed   = 1'b1;
               end else if (expm) begin
                  act.pass_v = 1'b1;
                  phase_in   = P_EXP0;
                  consumed   = 1'b1;
               end
               act.pass_branch = 1'b1;
            end
            P_EXP0: begin
               if (c == C_DIGIT || c == C_PLUS || c == C_DASH) begin
                  act.pass_v = 1'b1;
                  phase_in   = P_EXPD;
               end else begin
                  act.stop_v   = 1'b1;
                  act.stop_err = ntsp_pkg::ERR_EXPONENT;
                  halt_in      = 1'b1;
               end
               act.pass_branch = 1'b1;
               consumed        = 1'b1;
            end
            P_EXPD: begin
               if (c == C_DIGIT) begin
                  act.pass_v = 1'b1;
                  consumed   = 1'b1;
               end
               act.pass_branch = 1'b1;
            end
            default: ;
         endcase

         // start a new token and check it against the one before
         if (!consumed) begin
            phase_in = P_BETWEEN;
            case (c)
               C_WS, C_IGN: ;
               C_LSQ: phase_in = P_COMMENT;
               C_OPEN: begin
                  if (prev_ff != T_COMMA && prev_ff != T_OPEN && prev_ff != T_FIRST) begin
                     act.stop_v = 1'b1; act.stop_err = ntsp_pkg::ERR_OPEN;
                  end else if (open_cnt >= DEPTH_FULL || pend_cnt >= DEPTH_FULL) begin
                     act.stop_v = 1'b1; act.stop_err = ntsp_pkg::ERR_OVERFLOW;
                  end else begin
                     intc_in      = intc_ff + 16'd1;
                     open_op.push = 1'b1;
                     pend_op.push = 1'b1;
                     prev_in      = T_OPEN;
                  end
               end
               C_CLOSE: begin
                  if (prev_ff != T_LABEL && prev_ff != T_COMMA && prev_ff != T_CLOSE &&
                      prev_ff != T_BRANCH) begin
                     act.stop_v = 1'b1; act.stop_err = ntsp_pkg::ERR_CLOSE;
                  end else if (open_cnt == '0) begin
                     act.stop_v = 1'b1; act.stop_err = ntsp_pkg::ERR_UNBALANCED;
                  end else begin
                     rec_pend    = (prev_ff == T_CLOSE);
                     rec_tip     = (prev_ff == T_COMMA);
                     open_op.pop = 1'b1;
                     prev_in     = T_CLOSE;
                  end
               end
               C_COMMA: begin
                  if (prev_ff != T_LABEL && prev_ff != T_COMMA && prev_ff != T_CLOSE &&
                      prev_ff != T_BRANCH && prev_ff != T_OPEN) begin
                     act.stop_v = 1'b1; act.stop_err = ntsp_pkg::ERR_COMMA;
                  end else begin
                     rec_pend = (prev_ff == T_CLOSE);
                     rec_tip  = (prev_ff == T_OPEN) || (prev_ff == T_COMMA);
                     prev_in  = T_COMMA;
                  end
               end
               C_COLON: begin
                  if (prev_ff != T_LABEL && prev_ff != T_COMMA && prev_ff != T_CLOSE &&
                      prev_ff != T_OPEN) begin
                     act.stop_v = 1'b1; act.stop_err = ntsp_pkg::ERR_COLON;
                  end else if (open_cnt == '0) begin
                     act.stop_v = 1'b1; act.stop_err = ntsp_pkg::ERR_NONE;
                  end else begin
                     rec_pend = (prev_ff == T_CLOSE);
                     rec_tip  = (prev_ff != T_CLOSE) && (prev_ff != T_LABEL);
                     prev_in  = T_COLON;
                  end
               end
               C_SEMI: begin
                  if (prev_ff != T_LABEL && prev_ff != T_CLOSE && prev_ff != T_BRANCH) begin
                     act.stop_v = 1'b1; act.stop_err = ntsp_pkg::ERR_SEMI;
                  end else begin
                     prev_in = T_SEMI;
                  end
               end
               C_LABEL, C_DIGIT, C_PLUS, C_DASH, C_DOT: begin
                  if (prev_ff == T_COLON) begin
                     if (c != C_DASH && c != C_PLUS && c != C_DIGIT) begin
                        act.stop_v = 1'b1; act.stop_err = ntsp_pkg::ERR_LENGTH;
                     end else begin
                        act.pass_v      = 1'b1;
                        act.pass_branch = 1'b1;
                        prev_in         = T_BRANCH;
                        phase_in        = P_INT;
                     end
                  end else if (prev_ff != T_OPEN && prev_ff != T_COMMA &&
                               prev_ff != T_CLOSE) begin
                     act.stop_v = 1'b1; act.stop_err = ntsp_pkg::ERR_LABEL;
                  end else if (open_cnt == '0) begin
                     act.stop_v = 1'b1; act.stop_err = ntsp_pkg::ERR_NONE;
                  end else begin
                     rec_pend        = (prev_ff == T_CLOSE);
                     rec_tip         = (prev_ff != T_CLOSE);
                     act.pass_v      = 1'b1;
                     act.pass_branch = 1'b0;
                     prev_in         = T_LABEL;
                     phase_in        = P_LABEL;
                  end
               end
               default: begin
                  act.stop_v = 1'b1; act.stop_err = ntsp_pkg::ERR_BYTE;
               end
            endcase
            if (act.stop_v) halt_in = 1'b1;
         end

         // edge record: child from the pending stack or the next tip
         if (rec_pend || rec_tip) begin
            act.rec_v      = 1'b1;
            act.rec_edge   = edge_ff;
            act.rec_parent = otop;
            edge_in        = edge_ff + 16'd1;
            if (rec_pend) begin
               act.rec_child = (pend_cnt != '0) ? pend_top : 16'd0;
               pend_op.pop   = (pend_cnt != '0);
            end else begin
               tipc_in       = tipc_ff + 16'd1;
               act.rec_child = tipc_in & ntsp_pkg::NODE_MASK;
            end
         end

         act.pass_char = text_byte;
         act.pass_edge = edge_in - 16'd1;

         // final byte closes the text
         if (end_of_text && !halt_in) begin
            act.stop_v = 1'b1;
            if (phase_in == P_COMMENT) begin
               act.stop_err = ntsp_pkg::ERR_COMMENT;
            end else if (phase_in == P_EXP0) begin
               act.stop_err = ntsp_pkg::ERR_EXPONENT;
            end else begin
               act.stop_err = ntsp_pkg::ERR_NONE;
            end
            halt_in  = 1'b1;
            phase_in = P_BETWEEN;
         end
      end

      if (!accept) begin
         open_op = '0;
         pend_op = '0;
      end
   end

   assign push_id  = intc_in & ntsp_pkg::NODE_MASK;
   assign act_push = accept && (act.rec_v || act.pass_v || act.stop_v);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= P_BETWEEN;
         prev_ff  <= T_FIRST;
         tipc_ff  <= 16'd0;
         intc_ff  <= 16'd1;
         edge_ff  <= 16'd0;
         halt_ff  <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff <= phase_in;
            prev_ff  <= prev_in;
            tipc_ff  <= tipc_in;
            intc_ff  <= intc_in;
            edge_ff  <= edge_in;
            halt_ff  <= halt_in;
         end
         // the tip count only seeds internal ids before the first token
         if (csr_wr_en && prev_ff == T_FIRST && open_cnt == '0) intc_ff <= csr_wr_data;
      end
   end

endmodule

// ----- rtl/ntsp_queue.sv -----
module ntsp_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  ntsp_pkg::action_type push_data,
   input  logic                 pop,
   output ntsp_pkg::action_type head,
   output logic                 empty,
   output logic                 full
);

   localparam int AW = ntsp_pkg::QUEUE_AW;

   ntsp_pkg::action_type mem_ff [ntsp_pkg::QUEUE_DEPTH];
   logic [AW-1:0] wr_ff, rd_ff;
   logic [AW:0]   cnt_ff;

   assign empty = (cnt_ff == '0);
   assign full  = (cnt_ff == (AW+1)'(ntsp_pkg::QUEUE_DEPTH));
   assign head  = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 1'b1;
         if (pop)  rd_ff <= rd_ff + 1'b1;
         if (push && !pop) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
      if (push) mem_ff[wr_ff] <= push_data;
   end

endmodule

// ----- rtl/ntsp_back.sv -----
module ntsp_back (
   input  logic                 clock,
   input  logic                 reset,
   input  ntsp_pkg::action_type head,
   input  logic                 empty,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [2:0]           rsp_kind,
   output logic [15:0]          rsp_edge_index,
   output logic [15:0]          rsp_parent_node,
   output logic [15:0]          rsp_child_node,
   output logic [7:0]           rsp_char_out,
   output logic [3:0]           rsp_error_code,
   output logic                 rsp_last_of_run
);

   logic [2:0]  done_ff;
   logic [2:0]  avail, pick, rest;
   logic        load;
   logic        valid_ff;
   logic [2:0]  kind_ff;
   logic [15:0] edge_ff, parent_ff, child_ff;
   logic [7:0]  char_ff;
   logic [3:0]  err_ff;
   logic        last_ff;

   // bit 0 record, bit 1 passed byte, bit 2 stop
   assign avail = {head.stop_v, head.pass_v, head.rec_v} & ~done_ff;
   assign pick  = avail & (~avail + 3'd1);
   assign rest  = avail & ~pick;
   assign load  = !empty && (!valid_ff || !rsp_stall);
   assign pop   = load && (rest == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         done_ff  <= '0;
      end else begin
         if (load) begin
            valid_ff <= 1'b1;
            done_ff  <= (rest == '0) ? 3'd0 : (done_ff | pick);
         end else if (!rsp_stall) begin
            valid_ff <= 1'b0;
         end
      end
      if (load) begin
         last_ff   <= (rest == '0);
         kind_ff   <= ntsp_pkg::KIND_STOP;
         edge_ff   <= 16'd0;
         parent_ff <= 16'd0;
         child_ff  <= 16'd0;
         char_ff   <= 8'd0;
         err_ff    <= ntsp_pkg::ERR_NONE;
         if (pick[0]) begin
            kind_ff   <= ntsp_pkg::KIND_RECORD;
            edge_ff   <= head.rec_edge;
            parent_ff <= head.rec_parent;
            child_ff  <= head.rec_child;
         end else if (pick[1]) begin
            kind_ff <= head.pass_branch ? ntsp_pkg::KIND_BRANCH : ntsp_pkg::KIND_LABEL;
            edge_ff <= head.pass_edge;
            char_ff <= head.pass_char;
         end else begin
            err_ff <= head.stop_err;
         end
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_kind        = kind_ff;
   assign rsp_edge_index  = edge_ff;
   assign rsp_parent_node = parent_ff;
   assign rsp_child_node  = child_ff;
   assign rsp_char_out    = char_ff;
   assign rsp_error_code  = err_ff;
   assign rsp_last_of_run = last_ff;

endmodule

// ----- rtl/newick_tree_stream_parser.sv -----
// Channel | Direction | Handshake            | Payload
// req     | in        | req_valid/req_stall  | text_byte, end_of_text
// rsp     | out       | rsp_valid/rsp_stall  | kind, edge_index, parent/child node,
//         |           |                      | char_out, error_code, last_of_run
// csr     | in        | csr_wr_en            | csr_wr_data (tip count)
//
// One text byte is taken per cycle unless req_stall is high; the front end
// decodes it in that cycle. A byte gives zero to three results; the back end
// sends one result per cycle unless rsp_stall is high.
// req_stall rises only when the four-entry action queue is full.
// Reset is synchronous; no clearing pass is needed, the stacks are empty.
module newick_tree_stream_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_text_byte,
   input  logic        req_end_of_text,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_kind,
   output logic [15:0] rsp_edge_index,
   output logic [15:0] rsp_parent_node,
   output logic [15:0] rsp_child_node,
   output logic [7:0]  rsp_char_out,
   output logic [3:0]  rsp_error_code,
   output logic        rsp_last_of_run,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   logic                        accept;
   logic                        q_full, q_empty, q_pop, act_push;
   ntsp_pkg::action_type        act, head;
   ntsp_pkg::stack_op_type      open_op, pend_op;
   logic [15:0]                 push_id, open_top, pend_top;
   logic [ntsp_pkg::STACK_AW:0] open_cnt, pend_cnt;

   // hold the input only while the queue has no free slot
   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   ntsp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .text_byte   (req_text_byte),
      .end_of_text (req_end_of_text),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .open_top    (open_top),
      .open_cnt    (open_cnt),
      .pend_top    (pend_top),
      .pend_cnt    (pend_cnt),
      .open_op     (open_op),
      .pend_op     (pend_op),
      .push_id     (push_id),
      .act_push    (act_push),
      .act         (act)
   );

   // open internal nodes; depth doubles as the parenthesis depth
   ntsp_stack u_open (
      .clock     (clock),
      .reset     (reset),
      .op        (open_op),
      .push_data (push_id),
      .top       (open_top),
      .count     (open_cnt)
   );

   // internal nodes still waiting for their own edge record
   ntsp_stack u_pend (
      .clock     (clock),
      .reset     (reset),
      .op        (pend_op),
      .push_data (push_id),
      .top       (pend_top),
      .count     (pend_cnt)
   );

   ntsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (act_push),
      .push_data (act),
      .pop       (q_pop),
      .head      (head),
      .empty     (q_empty),
      .full      (q_full)
   );

   ntsp_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head),
      .empty           (q_empty),
      .pop             (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_edge_index  (rsp_edge_index),
      .rsp_parent_node (rsp_parent_node),
      .rsp_child_node  (rsp_child_node),
      .rsp_char_out    (rsp_char_out),
      .rsp_error_code  (rsp_error_code),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

// ----- rtl/ntsp_checker.sv -----
module ntsp_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [2:0] rsp_kind,
   input logic [3:0] rsp_error_code,
   input logic       rsp_last_of_run
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_kind))
      else $error("stalled result changed");

   a_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_kind >= ntsp_pkg::KIND_RECORD && rsp_kind <= ntsp_pkg::KIND_STOP)
      else $error("bad result kind");

   a_err: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != ntsp_pkg::KIND_STOP |-> rsp_error_code == ntsp_pkg::ERR_NONE)
      else $error("error code outside a stop result");

   a_stop_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == ntsp_pkg::KIND_STOP |-> rsp_last_of_run)
      else $error("stop result not last of its byte");

   a_halt: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_kind == ntsp_pkg::KIND_STOP |=> !rsp_valid)
      else $error("result after stop");

endmodule

bind newick_tree_stream_parser ntsp_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_kind        (rsp_kind),
   .rsp_error_code  (rsp_error_code),
   .rsp_last_of_run (rsp_last_of_run)
);

// ----- tb/tb.sv -----
module tb;

   // lexer token and byte class codes used by the predictor
   typedef enum logic [3:0] {
      TOK_FIRST, TOK_OPEN, TOK_CLOSE, TOK_COMMA, TOK_COLON, TOK_SEMI, TOK_LABEL, TOK_BRANCH
   } token_type;

   typedef enum logic [3:0] {
      CLS_IGN, CLS_WS, CLS_LABEL, CLS_OPEN, CLS_CLOSE, CLS_PLUS, CLS_COMMA, CLS_DASH,
      CLS_DOT, CLS_DIGIT, CLS_COLON, CLS_SEMI, CLS_LSQ, CLS_RSQ, CLS_BAD
   } class_type;

   typedef enum logic [3:0] {
      PH_BETWEEN, PH_COMMENT, PH_LABEL, PH_INT, PH_FRAC, PH_EXP0, PH_EXPD
   } phase_type;

   // how the text stream is finished off; only one stop is possible per run
   typedef enum int {
      END_SEMI, END_ROOT_LABEL, END_OPEN_COMMENT, END_HIGH_BYTE, END_EXTRA_CLOSE,
      END_REOPEN, END_STRAY_BRACKET, END_OVERFLOW, END_EXPONENT, END_COUNT
   } ending_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [15:0] edge_index;
      logic [15:0] parent_node;
      logic [15:0] child_node;
      logic [7:0]  char_out;
      logic [3:0]  error_code;
      logic        last_of_run;
   } parse_result_type;

   class scoreboard_type;
      logic [15:0] open_stk [ntsp_pkg::STACK_DEPTH];
      logic [15:0] pend_stk [ntsp_pkg::STACK_DEPTH];
      int          open_ptr;
      int          pend_ptr;
      token_type   prev_tok;
      phase_type   phase;
      logic [15:0] tips;
      logic [15:0] internals;
      logic [15:0] edges;
      bit          halted;
      int          step_n;
      int          fails;
      parse_result_type expected_q[$];

      function new();
         open_ptr = 0;
         pend_ptr = 0;
         prev_tok = TOK_FIRST;
         phase = PH_BETWEEN;
         tips = '0;
         internals = 16'd1;
         edges = '0;
         halted = 0;
         fails = 0;
      endfunction

      function void write_tip_count(logic [15:0] v);
         if (prev_tok == TOK_FIRST && open_ptr == 0) internals = v;
      endfunction

      function class_type class_of(logic [7:0] b);
         if (b >= 8'd128) return CLS_BAD;
         if (b == 8'd9 || b == 8'd10 || b == 8'd13 || b == 8'd32) return CLS_WS;
         if (b < 8'd32 || b == 8'd127) return CLS_IGN;
         if (b >= "0" && b <= "9") return CLS_DIGIT;
         case (b)
            "(": return CLS_OPEN;
            ")": return CLS_CLOSE;
            "+": return CLS_PLUS;
            ",": return CLS_COMMA;
            "-": return CLS_DASH;
            ".": return CLS_DOT;
            ":": return CLS_COLON;
            ";": return CLS_SEMI;
            "[": return CLS_LSQ;
            "]": return CLS_RSQ;
            default: return CLS_LABEL;
         endcase
      endfunction

      function void put(logic [2:0] kind, logic [15:0] e, logic [15:0] par,
                        logic [15:0] chi, logic [7:0] ch, logic [3:0] err);
         parse_result_type r;
         if (step_n >= 3) return;
         r = '{kind, e, par, chi, ch, err, 1'b0};
         expected_q.push_back(r);
         step_n++;
      endfunction

      function void halt(logic [3:0] err);
         put(ntsp_pkg::KIND_STOP, '0, '0, '0, '0, err);
         halted = 1;
      endfunction

      function void add_edge(logic [15:0] child);
         put(ntsp_pkg::KIND_RECORD, edges, open_ptr > 0 ? open_stk[open_ptr-1] : 16'd0,
             child, '0, ntsp_pkg::ERR_NONE);
         edges++;
      endfunction

      function void edge_to_pending();
         add_edge(pend_ptr > 0 ? pend_stk[pend_ptr-1] : 16'd0);
         if (pend_ptr > 0) pend_ptr--;
      endfunction

      function void edge_to_tip();
         tips++;
         add_edge(tips & ntsp_pkg::NODE_MASK);
      endfunction

      function void pass(logic [2:0] kind, logic [7:0] b);
         put(kind, edges - 16'd1, '0, '0, b, ntsp_pkg::ERR_NONE);
      endfunction

      function void begin_token(logic [7:0] b, class_type c);
         token_type p;
         p = prev_tok;
         case (c)
            CLS_WS, CLS_IGN: ;
            CLS_LSQ: phase = PH_COMMENT;
            CLS_OPEN: begin
               if (p != TOK_COMMA && p != TOK_OPEN && p != TOK_FIRST) halt(ntsp_pkg::ERR_OPEN);
               else if (open_ptr >= ntsp_pkg::STACK_DEPTH || pend_ptr >= ntsp_pkg::STACK_DEPTH)
                  halt(ntsp_pkg::ERR_OVERFLOW);
               else begin
                  internals++;
                  open_stk[open_ptr++] = internals & ntsp_pkg::NODE_MASK;
                  pend_stk[pend_ptr++] = internals & ntsp_pkg::NODE_MASK;
                  prev_tok = TOK_OPEN;
               end
            end
            CLS_CLOSE: begin
               if (!(p inside {TOK_LABEL, TOK_COMMA, TOK_CLOSE, TOK_BRANCH}))
                  halt(ntsp_pkg::ERR_CLOSE);
               else if (open_ptr == 0) halt(ntsp_pkg::ERR_UNBALANCED);
               else begin
                  if (p == TOK_CLOSE) edge_to_pending();
                  else if (p == TOK_COMMA) edge_to_tip();
                  open_ptr--;
                  prev_tok = TOK_CLOSE;
               end
            end
            CLS_COMMA: begin
               if (!(p inside {TOK_LABEL, TOK_COMMA, TOK_CLOSE, TOK_BRANCH, TOK_OPEN}))
                  halt(ntsp_pkg::ERR_COMMA);
               else begin
                  if (p == TOK_CLOSE) edge_to_pending();
                  else if (p == TOK_OPEN || p == TOK_COMMA) edge_to_tip();
                  prev_tok = TOK_COMMA;
               end
            end
            CLS_COLON: begin
               if (!(p inside {TOK_LABEL, TOK_COMMA, TOK_CLOSE, TOK_OPEN}))
                  halt(ntsp_pkg::ERR_COLON);
               else if (open_ptr == 0) halt(ntsp_pkg::ERR_NONE);
               else begin
                  if (p == TOK_CLOSE) edge_to_pending();
                  else if (p != TOK_LABEL) edge_to_tip();
                  prev_tok = TOK_COLON;
               end
            end
            CLS_SEMI: begin
               if (!(p inside {TOK_LABEL, TOK_CLOSE, TOK_BRANCH})) halt(ntsp_pkg::ERR_SEMI);
               else prev_tok = TOK_SEMI;
            end
            CLS_LABEL, CLS_DIGIT, CLS_PLUS, CLS_DASH, CLS_DOT: begin
               if (p == TOK_COLON) begin
                  if (c != CLS_DASH && c != CLS_PLUS && c != CLS_DIGIT)
                     halt(ntsp_pkg::ERR_LENGTH);
                  else begin
                     pass(ntsp_pkg::KIND_BRANCH, b);
                     prev_tok = TOK_BRANCH;
                     phase = PH_INT;
                  end
               end else if (!(p inside {TOK_OPEN, TOK_COMMA, TOK_CLOSE}))
                  halt(ntsp_pkg::ERR_LABEL);
               else if (open_ptr == 0) halt(ntsp_pkg::ERR_NONE);
               else begin
                  if (p == TOK_CLOSE) edge_to_pending();
                  else edge_to_tip();
                  pass(ntsp_pkg::KIND_LABEL, b);
                  prev_tok = TOK_LABEL;
                  phase = PH_LABEL;
               end
            end
            default: halt(ntsp_pkg::ERR_BYTE);
         endcase
      endfunction

      function void note_byte(logic [7:0] b, logic eot);
         class_type c;
         bit     taken;
         bit     is_exp;
         c = class_of(b);
         taken = 0;
         is_exp = (b == "E" || b == "e");
         step_n = 0;
         if (halted) return;
         case (phase)
            PH_COMMENT: begin
               if (b == "]") phase = PH_BETWEEN;
               taken = 1;
            end
            PH_LABEL:
               if (c inside {CLS_LABEL, CLS_DIGIT, CLS_DOT, CLS_PLUS, CLS_DASH}) begin
                  pass(ntsp_pkg::KIND_LABEL, b);
                  taken = 1;
               end
            PH_INT, PH_FRAC:
               if (c == CLS_DIGIT) begin
                  pass(ntsp_pkg::KIND_BRANCH, b);
                  taken = 1;
               end else if (c == CLS_DOT && phase == PH_INT) begin
                  pass(ntsp_pkg::KIND_BRANCH, b);
                  phase = PH_FRAC;
                  taken = 1;
               end else if (is_exp) begin
                  pass(ntsp_pkg::KIND_BRANCH, b);
                  phase = PH_EXP0;
                  taken = 1;
               end
            PH_EXP0: begin
               if (c inside {CLS_DIGIT, CLS_PLUS, CLS_DASH}) begin
                  pass(ntsp_pkg::KIND_BRANCH, b);
                  phase = PH_EXPD;
               end else halt(ntsp_pkg::ERR_EXPONENT);
               taken = 1;
            end
            PH_EXPD:
               if (c == CLS_DIGIT) begin
                  pass(ntsp_pkg::KIND_BRANCH, b);
                  taken = 1;
               end
            default: ;
         endcase
         if (!taken && !halted) begin
            phase = PH_BETWEEN;
            begin_token(b, c);
         end
         if (eot && !halted) begin
            if (phase == PH_COMMENT) halt(ntsp_pkg::ERR_COMMENT);
            else if (phase == PH_EXP0) halt(ntsp_pkg::ERR_EXPONENT);
            else halt(ntsp_pkg::ERR_NONE);
            phase = PH_BETWEEN;
         end
         if (step_n > 0) expected_q[$].last_of_run = 1'b1;
      endfunction

      function void check_result(parse_result_type got);
         parse_result_type exp_r;
         if (expected_q.size() == 0) begin
            fails++;
            $display("%0t unexpected result: kind=%0d edge=%0d par=%0d chi=%0d ch=%h err=%0d",
                     $time, got.kind, got.edge_index, got.parent_node, got.child_node,
                     got.char_out, got.error_code);
            return;
         end
         exp_r = expected_q.pop_front();
         if (got !== exp_r) begin
            fails++;
            $display("%0t mismatch expected: kind=%0d edge=%0d par=%0d chi=%0d ch=%h err=%0d last=%0d",
                     $time, exp_r.kind, exp_r.edge_index, exp_r.parent_node,
                     exp_r.child_node, exp_r.char_out, exp_r.error_code, exp_r.last_of_run);
            $display("%0t mismatch actual:   kind=%0d edge=%0d par=%0d chi=%0d ch=%h err=%0d last=%0d",
                     $time, got.kind, got.edge_index, got.parent_node, got.child_node,
                     got.char_out, got.error_code, got.last_of_run);
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_text_byte;
   logic        req_end_of_text;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [2:0]  rsp_kind;
   logic [15:0] rsp_edge_index;
   logic [15:0] rsp_parent_node;
   logic [15:0] rsp_child_node;
   logic [7:0]  rsp_char_out;
   logic [3:0]  rsp_error_code;
   logic        rsp_last_of_run;
   logic        csr_wr_en;
   logic [15:0] csr_wr_data;

   scoreboard_type sb;
   logic [7:0] text_q[$];
   int  sent_n;
   bit  quiet;
   bit  long_hold_done;

   newick_tree_stream_parser DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_text_byte  (req_text_byte),
      .req_end_of_text(req_end_of_text),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_kind       (rsp_kind),
      .rsp_edge_index (rsp_edge_index),
      .rsp_parent_node(rsp_parent_node),
      .rsp_child_node (rsp_child_node),
      .rsp_char_out   (rsp_char_out),
      .rsp_error_code (rsp_error_code),
      .rsp_last_of_run(rsp_last_of_run),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // hard stop in case the block hangs
   initial begin
      #3000000;
      $display("FAILED: results differ");
      $finish;
   end

   // --- text generation -------------------------------------------------

   // drop whitespace, control bytes or a comment between tokens now and then
   function automatic void add_filler();
      int sel;
      int k;
      logic [7:0] b;
      sel = $urandom_range(0, 9);
      if (sel == 0) text_q.push_back(8'd32);
      else if (sel == 1) text_q.push_back(8'd10);
      else if (sel == 2) text_q.push_back(8'($urandom_range(0, 31)) | 8'd1);
      else if (sel == 3) begin
         // comment body takes any byte but the closing bracket
         text_q.push_back("[");
         for (k = $urandom_range(0, 5); k > 0; k--) begin
            b = 8'($urandom);
            if (b == "]") b = 8'hFF;
            text_q.push_back(b);
         end
         text_q.push_back("]");
      end
   endfunction

   function automatic void add_label();
      int k;
      int sel;
      for (k = $urandom_range(1, 4); k > 0; k--) begin
         sel = $urandom_range(0, 5);
         if (sel < 3) text_q.push_back(8'($urandom_range("A", "Z")) | (sel == 0 ? 8'h20 : 8'h00));
         else if (sel == 3) text_q.push_back(8'($urandom_range("0", "9")));
         else text_q.push_back(sel == 4 ? "_" : ".");
      end
   endfunction

   function automatic void add_digits();
      int k;
      for (k = $urandom_range(1, 3); k > 0; k--) text_q.push_back(8'($urandom_range("0", "9")));
   endfunction

   function automatic void add_length();
      text_q.push_back(":");
      add_filler();
      case ($urandom_range(0, 2))
         0: text_q.push_back("-");
         1: text_q.push_back("+");
         default: ;
      endcase
      add_digits();
      if ($urandom_range(0, 1)) begin
         text_q.push_back(".");
         if ($urandom_range(0, 3)) add_digits();
      end
      if ($urandom_range(0, 2) == 0) begin
         text_q.push_back($urandom_range(0, 1) ? "e" : "E");
         case ($urandom_range(0, 2))
            0: text_q.push_back("-");
            1: text_q.push_back("+");
            default: ;
         endcase
         add_digits();
      end
   endfunction

   function automatic void add_child(int lvl);
      if (lvl < 6 && $urandom_range(0, 3) == 0) begin
         add_clade(lvl + 1);
         return;
      end
      case ($urandom_range(0, 4))
         0: ;
         1: add_label();
         2: add_length();
         default: begin
            add_label();
            add_length();
         end
      endcase
   endfunction

   function automatic void add_clade(int lvl);
      int k;
      text_q.push_back("(");
      add_filler();
      add_child(lvl);
      for (k = $urandom_range(0, 3); k > 0; k--) begin
         add_filler();
         text_q.push_back(",");
         add_filler();
         add_child(lvl);
      end
      add_filler();
      text_q.push_back(")");
      if ($urandom_range(0, 1)) add_label();
      if ($urandom_range(0, 1)) add_length();
   endfunction

   function automatic void build_text();
      string  lead;
      int     k;
      ending_type how;
      // directed opening: signed lengths with fraction and exponent, empty tips,
      // a comment, internal label, tip with only a length, control bytes
      lead = "(Ab_1:+1.25e-3,(,x.y-z:0)[note]q:-7E+2,\t:5e9,(,), ";
      for (k = 0; k < lead.len(); k++) text_q.push_back(lead[k]);
      text_q.push_back(8'h01);
      text_q.push_back(8'h7F);
      add_child(1);
      while (text_q.size() < 480) begin
         add_filler();
         text_q.push_back(",");
         add_filler();
         add_child(1);
      end
      how = ending_type'($urandom_range(0, END_COUNT - 1));
      if (how == END_OVERFLOW) begin
         text_q.push_back(",");
         for (k = 0; k < ntsp_pkg::STACK_DEPTH + 4; k++) text_q.push_back("(");
      end else if (how == END_EXPONENT) begin
         text_q.push_back(",");
         text_q.push_back("T");
         text_q.push_back(":");
         text_q.push_back("1");
         text_q.push_back("e");
      end else begin
         text_q.push_back(")");
         case (how)
            END_SEMI: text_q.push_back(";");
            END_ROOT_LABEL: text_q.push_back("R");
            END_OPEN_COMMENT: begin
               text_q.push_back("[");
               text_q.push_back(8'hA5);
            end
            END_HIGH_BYTE: text_q.push_back(8'($urandom_range(128, 255)));
            END_EXTRA_CLOSE: text_q.push_back(")");
            END_REOPEN: text_q.push_back("(");
            default: text_q.push_back("]");
         endcase
         text_q.push_back(8'd32);
      end
   endfunction

   // --- drivers -----------------------------------------------------------

   task automatic send_byte(logic [7:0] b, logic eot);
      req_valid       <= 1'b1;
      req_text_byte   <= b;
      req_end_of_text <= eot;
      do @(posedge clock); while (req_stall);
      sb.note_byte(b, eot);
      sent_n++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      // a byte may still be in flight without any result
      repeat (8) @(posedge clock);
   endtask

   task automatic write_tip_count(logic [15:0] v);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.write_tip_count(v);
   endtask

   // receiver: random stall bursts, one long hold-off, none near the end
   initial begin
      rsp_stall = 1'b0;
      @(negedge reset);
      @(posedge clock);
      forever begin
         if (!long_hold_done && sent_n >= 150) begin
            long_hold_done = 1;
            rsp_stall <= 1'b1;
            repeat (300) @(posedge clock);
         end else if (quiet || $urandom_range(0, 2) != 0) begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 13)) @(posedge clock);
         end
      end
   end

   // check every accepted result against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result('{rsp_kind, rsp_edge_index, rsp_parent_node, rsp_child_node,
                           rsp_char_out, rsp_error_code, rsp_last_of_run});
   end

   initial begin
      int i;
      int n;
      logic [15:0] tip_vals [4];
      sb = new();
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_text_byte   = '0;
      req_end_of_text = 1'b0;
      csr_wr_en       = 1'b0;
      csr_wr_data     = '0;
      sent_n          = 0;
      quiet           = 0;
      long_hold_done  = 0;
      build_text();
      // first write lands before any token, so it sets the internal ids
      tip_vals = '{16'd32768, 16'd1, 16'($urandom_range(1, 32768)), 16'd32768};
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_tip_count(tip_vals[0]);
      n = text_q.size();
      for (i = 0; i < n; i++) begin
         // phase boundaries: drain, then rewrite the register
         if (i == 160 || i == 320 || i == 400) begin
            wait_drained();
            write_tip_count(tip_vals[i / 130]);
         end
         if (n - i < 60) quiet = 1;
         if (!quiet && $urandom_range(0, 3) == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clock);
         end
         send_byte(text_q[i], i == n - 1);
      end
      req_valid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.fails == 0 && sb.expected_q.size() == 0) $display("PASSED: all results match");
      else $display("FAILED: results differ");
      $finish;
   end

endmodule
